FILE: sv/srs_pkg.sv
// ----------------------------------------------------------------------------
// Stepper ramp sequencer package
// Shared constants, command codes and record types of the motor bank.
// ----------------------------------------------------------------------------
package srs_pkg;

	localparam int MOTORS     = 4;
	localparam int COUNT_BITS = 16;
	localparam int MIDX_W     = (MOTORS > 1) ? $clog2(MOTORS) : 1;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_MOTION = 2'd1;
	localparam logic [1:0] CMD_COUNT  = 2'd2;
	localparam logic [1:0] CMD_START  = 2'd3;

	localparam logic [1:0] RUN_HOLD    = 2'd0;
	localparam logic [1:0] RUN_FWD     = 2'd1;
	localparam logic [1:0] RUN_REV     = 2'd2;
	localparam logic [1:0] RUN_ILLEGAL = 2'd3;

	localparam logic [1:0] STOP_RUN     = 2'd0;
	localparam logic [1:0] STOP_HOLD    = 2'd1;
	localparam logic [1:0] STOP_RELEASE = 2'd2;
	localparam logic [1:0] STOP_REVERSE = 2'd3;

	localparam logic [1:0] CNT_NONE    = 2'd0;
	localparam logic [1:0] CNT_UP      = 2'd1;
	localparam logic [1:0] CNT_DOWN    = 2'd2;
	localparam logic [1:0] CNT_ILLEGAL = 2'd3;

	localparam logic [3:0] RATE_SLOWEST = 4'd15;
	localparam logic [2:0] PHASE_TOP    = 3'd7;

	typedef struct packed {
		logic [1:0]            motion;
		logic [1:0]            stop;
		logic [3:0]            div;
		logic [3:0]            rate;
		logic [3:0]            goal;
		logic [2:0]            phase;
		logic [1:0]            cmode;
		logic [COUNT_BITS-1:0] cnt;
	} motor_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  run_state;
		logic [1:0]  stop_mode;
		logic [3:0]  target_rate;
		logic [3:0]  start_rate;
		logic [1:0]  count_mode;
		logic [15:0] count_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  motor_id;
		logic [2:0]  phase;
		logic        drive;
		logic        release_res;
		logic [1:0]  run_state;
		logic [15:0] step_count;
		logic        last;
	} res_t;

endpackage

FILE: sv/srs_state_mem.sv
// ----------------------------------------------------------------------------
// Motor state memory
// One record per motor, synchronous read with registered data. Entries that
// have not been written since reset read as all zero.
// ----------------------------------------------------------------------------
module srs_state_mem
	import srs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [MIDX_W-1:0] rd_addr,
	output motor_t            rd_data,
	input  logic              wr_en,
	input  logic [MIDX_W-1:0] wr_addr,
	input  motor_t            wr_data
);

	motor_t              ram [MOTORS];
	motor_t              ram_rd_q;
	logic [MOTORS-1:0]   vld_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_rd_q <= ram[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? ram_rd_q : '0;

endmodule

FILE: sv/srs_motor_update.sv
// ----------------------------------------------------------------------------
// Motor record update
// Applies a command or one tick step to a motor record and forms the result.
// ----------------------------------------------------------------------------
module srs_motor_update
	import srs_pkg::*;
(
	input  motor_t            st,
	input  req_t              req,
	input  logic [MIDX_W-1:0] idx,
	output motor_t            nx,
	output res_t              res
);

	logic [1:0] ms;
	logic [3:0] rate;
	logic       drv;
	logic       rel;

	always_comb begin
		nx   = st;
		ms   = st.motion;
		rate = st.rate;
		drv  = 1'b0;
		rel  = 1'b0;
		case (req.cmd)
			CMD_MOTION: begin
				nx.motion = (req.run_state == RUN_ILLEGAL) ? RUN_HOLD : req.run_state;
				nx.stop   = req.stop_mode;
				nx.goal   = req.target_rate;
			end
			CMD_COUNT: begin
				nx.cmode = (req.count_mode == CNT_ILLEGAL) ? CNT_NONE : req.count_mode;
				nx.cnt   = COUNT_BITS'(req.count_value);
			end
			CMD_START: begin
				nx.rate = req.start_rate;
				nx.div  = req.start_rate;
			end
			default: begin
				if (st.motion == RUN_FWD || st.motion == RUN_REV) begin
					if (st.div != 4'd0) begin
						nx.div = st.div - 4'd1;
					end else begin
						if (st.stop == STOP_RUN) begin
							if (st.rate > st.goal) begin
								rate = st.rate - 4'd1;
							end else if (st.rate < st.goal) begin
								rate = st.rate + 4'd1;
							end
						end else if (st.rate >= RATE_SLOWEST) begin
							case (st.stop)
								STOP_HOLD: begin
									ms = RUN_HOLD;
								end
								STOP_RELEASE: begin
									ms  = RUN_HOLD;
									rel = 1'b1;
								end
								default: begin
									ms      = (st.motion == RUN_FWD) ? RUN_REV : RUN_FWD;
									nx.stop = STOP_RUN;
								end
							endcase
						end else begin
							rate = st.rate + 4'd1;
						end
						nx.rate = rate;
						nx.div  = rate;
						if (st.motion == RUN_FWD) begin
							nx.phase = (st.phase >= PHASE_TOP) ? 3'd0 : st.phase + 3'd1;
						end else begin
							nx.phase = (st.phase == 3'd0) ? PHASE_TOP : st.phase - 3'd1;
						end
						if (ms == st.motion) begin
							drv = 1'b1;
							if (st.cmode == CNT_UP) begin
								nx.cnt = st.cnt + COUNT_BITS'(1);
							end else if (st.cmode == CNT_DOWN) begin
								if (st.cnt == '0) begin
									ms = RUN_HOLD;
								end else begin
									nx.cnt = st.cnt - COUNT_BITS'(1);
								end
							end
						end
						nx.motion = ms;
					end
				end
			end
		endcase
	end

	assign res.motor_id    = 2'(idx);
	assign res.phase       = nx.phase;
	assign res.drive       = drv;
	assign res.release_res = rel;
	assign res.run_state   = nx.motion;
	assign res.step_count  = 16'(nx.cnt);
	assign res.last        = (idx == MIDX_W'(MOTORS - 1));

endmodule

FILE: sv/stepper_ramp_sequencer.sv
// ----------------------------------------------------------------------------
// Stepper ramp sequencer
// A command is accepted only in idle; for a motor in range its record is read,
// then updated and written back, and no new request is taken until idle again.
// A tick walks the motors in turn, each with a memory read, then update and
// write-back through the single state memory port pair; a write-back waits while
// an unaccepted result is still held for rsp_ready. The result for motor k is
// registered at its write-back. Reset clears all records.
module stepper_ramp_sequencer
	import srs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  cmd,
	input  logic [1:0]  motor,
	input  logic [1:0]  new_run_state,
	input  logic [1:0]  new_stop_mode,
	input  logic [3:0]  target_rate,
	input  logic [3:0]  start_rate,
	input  logic [1:0]  new_count_mode,
	input  logic [15:0] count_value,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  motor_id,
	output logic [2:0]  phase,
	output logic        drive,
	output logic        release_res,
	output logic [1:0]  run_state,
	output logic [15:0] step_count,
	output logic        last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]        state_q;
	logic [MIDX_W-1:0] k_q;
	req_t              req_q;
	res_t              res_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              rd_en;
	logic              wr_en;
	logic              out_free;
	logic              is_tick;
	logic              in_range;
	motor_t            rd_data;
	motor_t            nx;
	res_t              res;

	assign accept   = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign in_range = (5'(motor) < 5'(MOTORS));
	assign is_tick  = (req_q.cmd == CMD_TICK);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign rd_en    = (state_q == ST_READ);
	assign wr_en    = (state_q == ST_EXEC) && (!is_tick || out_free);

	srs_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (k_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (k_q),
		.wr_data (nx)
	);

	srs_motor_update u_upd (
		.st  (rd_data),
		.req (req_q),
		.idx (k_q),
		.nx  (nx),
		.res (res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.cmd         <= cmd;
			req_q.run_state   <= new_run_state;
			req_q.stop_mode   <= new_stop_mode;
			req_q.target_rate <= target_rate;
			req_q.start_rate  <= start_rate;
			req_q.count_mode  <= new_count_mode;
			req_q.count_value <= count_value;
		end
		if (wr_en && is_tick) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (wr_en && is_tick) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_TICK) begin
							k_q     <= '0;
							state_q <= ST_READ;
						end else if (in_range) begin
							k_q     <= MIDX_W'(motor);
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (wr_en) begin
						if (!is_tick || k_q == MIDX_W'(MOTORS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + MIDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign motor_id    = res_q.motor_id;
	assign phase       = res_q.phase;
	assign drive       = res_q.drive;
	assign release_res = res_q.release_res;
	assign run_state   = res_q.run_state;
	assign step_count  = res_q.step_count;
	assign last        = res_q.last;

`ifndef SYNTH
	a_read_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_EXEC)
		else $error("memory read not followed by update");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> 5'(k_q) < 5'(MOTORS))
		else $error("motor index out of range");

	a_no_result_on_command: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !is_tick) |=> !$rose(rsp_valid_q))
		else $error("result produced by a command request");
`endif

endmodule

FILE: tb/stepper_ramp_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper ramp sequencer testbench
// Drives command and tick requests into the motor bank and predicts every
// per-motor status from its own model of the ramp, stop and count behavior.
// A directed part covers the extremes and the corner cases. Random episodes
// then set up motors and tick them, some with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module stepper_ramp_sequencer_tb;
	import srs_pkg::*;

	localparam int         CYCLE_LIMIT  = 300000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  motor;
		logic [1:0]  run;
		logic [1:0]  stop;
		logic [3:0]  target;
		logic [3:0]  start;
		logic [1:0]  cmode;
		logic [15:0] value;
	} motor_req_t;

	localparam int REQ_W = $bits(motor_req_t);

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  cmd;
	logic [1:0]  motor;
	logic [1:0]  new_run_state;
	logic [1:0]  new_stop_mode;
	logic [3:0]  target_rate;
	logic [3:0]  start_rate;
	logic [1:0]  new_count_mode;
	logic [15:0] count_value;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [1:0]  motor_id;
	logic [2:0]  phase;
	logic        drive;
	logic        release_res;
	logic [1:0]  run_state;
	logic [15:0] step_count;
	logic        last;

	motor_t motor_model [MOTORS];
	res_t   status_q [$];
	int     mismatch_cnt = 0;
	int     sent_cnt = 0;
	int     cycle_cnt = 0;
	int     idle_pct = 0;
	int     stall_left = 0;

	stepper_ramp_sequencer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.cmd            (cmd),
		.motor          (motor),
		.new_run_state  (new_run_state),
		.new_stop_mode  (new_stop_mode),
		.target_rate    (target_rate),
		.start_rate     (start_rate),
		.new_count_mode (new_count_mode),
		.count_value    (count_value),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.motor_id       (motor_id),
		.phase          (phase),
		.drive          (drive),
		.release_res    (release_res),
		.run_state      (run_state),
		.step_count     (step_count),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic res_t advance_motor(input int m);
		motor_t     s;
		logic [1:0] dir;
		res_t       r;
		s = motor_model[m];
		dir = s.motion;
		r = '0;
		if (dir == RUN_FWD || dir == RUN_REV) begin
			if (s.div != 4'd0) begin
				s.div = s.div - 4'd1;
			end else begin
				if (s.stop == STOP_RUN) begin
					if (s.rate > s.goal)
						s.rate = s.rate - 4'd1;
					else if (s.rate < s.goal)
						s.rate = s.rate + 4'd1;
				end else if (s.rate == RATE_SLOWEST) begin
					if (s.stop == STOP_HOLD) begin
						s.motion = RUN_HOLD;
					end else if (s.stop == STOP_RELEASE) begin
						s.motion = RUN_HOLD;
						r.release_res = 1'b1;
					end else begin
						s.motion = (dir == RUN_FWD) ? RUN_REV : RUN_FWD;
						s.stop = STOP_RUN;
					end
				end else begin
					s.rate = s.rate + 4'd1;
				end
				s.div = s.rate;
				if (dir == RUN_FWD)
					s.phase = (s.phase == PHASE_TOP) ? 3'd0 : s.phase + 3'd1;
				else
					s.phase = (s.phase == 3'd0) ? PHASE_TOP : s.phase - 3'd1;
				if (s.motion == dir) begin
					r.drive = 1'b1;
					if (s.cmode == CNT_UP) begin
						s.cnt = s.cnt + 16'd1;
					end else if (s.cmode == CNT_DOWN) begin
						if (s.cnt == 16'd0)
							s.motion = RUN_HOLD;
						else
							s.cnt = s.cnt - 16'd1;
					end
				end
			end
		end
		motor_model[m] = s;
		r.motor_id = m[1:0];
		r.phase = s.phase;
		r.run_state = s.motion;
		r.step_count = s.cnt;
		r.last = (m == MOTORS - 1);
		return r;
	endfunction

	function automatic void apply_request(input motor_req_t rq);
		int m;
		m = rq.motor;
		if (rq.cmd == CMD_TICK) begin
			for (int k = 0; k < MOTORS; k++)
				status_q.push_back(advance_motor(k));
		end else if (m < MOTORS) begin
			case (rq.cmd)
				CMD_MOTION: begin
					motor_model[m].motion = (rq.run == RUN_ILLEGAL) ? RUN_HOLD : rq.run;
					motor_model[m].stop = rq.stop;
					motor_model[m].goal = rq.target;
				end
				CMD_COUNT: begin
					motor_model[m].cmode = (rq.cmode == CNT_ILLEGAL) ? CNT_NONE : rq.cmode;
					motor_model[m].cnt = rq.value;
				end
				default: begin
					motor_model[m].rate = rq.start;
					motor_model[m].div = rq.start;
				end
			endcase
		end
	endfunction

	function automatic motor_req_t noise_req(input logic [1:0] c);
		motor_req_t rq;
		rq = REQ_W'({$urandom, $urandom});
		rq.value = 16'($urandom);
		rq.cmd = c;
		return rq;
	endfunction

	function automatic motor_req_t tick_req();
		return noise_req(CMD_TICK);
	endfunction

	function automatic motor_req_t motion_req(input logic [1:0] m, input logic [1:0] run,
			input logic [1:0] stop, input logic [3:0] target);
		motor_req_t rq;
		rq = noise_req(CMD_MOTION);
		rq.motor = m;
		rq.run = run;
		rq.stop = stop;
		rq.target = target;
		return rq;
	endfunction

	function automatic motor_req_t count_req(input logic [1:0] m, input logic [1:0] mode,
			input logic [15:0] value);
		motor_req_t rq;
		rq = noise_req(CMD_COUNT);
		rq.motor = m;
		rq.cmode = mode;
		rq.value = value;
		return rq;
	endfunction

	function automatic motor_req_t start_req(input logic [1:0] m, input logic [3:0] rate);
		motor_req_t rq;
		rq = noise_req(CMD_START);
		rq.motor = m;
		rq.start = rate;
		return rq;
	endfunction

	task automatic send_request(input motor_req_t rq);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		req_valid = 1'b1;
		cmd = rq.cmd;
		motor = rq.motor;
		new_run_state = rq.run;
		new_stop_mode = rq.stop;
		target_rate = rq.target;
		start_rate = rq.start;
		new_count_mode = rq.cmode;
		count_value = rq.value;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		apply_request(rq);
		sent_cnt++;
		@(negedge clk);
	endtask

	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ready = 1'b0;
				stall_left--;
			end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				rsp_ready = 1'b0;
				stall_left = $urandom_range(1, 10) - 1;
			end else begin
				rsp_ready = 1'b1;
			end
		end
	end

	function automatic string fmt_status(input res_t r);
		return $sformatf("motor=%0d phase=%0d drive=%0d rel=%0d run=%0d count=%0d last=%0d",
			r.motor_id, r.phase, r.drive, r.release_res, r.run_state, r.step_count, r.last);
	endfunction

	task automatic note_failure(input string msg);
		if (mismatch_cnt < 10)
			$display("ERROR at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	always @(posedge clk) begin : status_check
		res_t got;
		res_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			got.motor_id = motor_id;
			got.phase = phase;
			got.drive = drive;
			got.release_res = release_res;
			got.run_state = run_state;
			got.step_count = step_count;
			got.last = last;
			if (status_q.size() == 0) begin
				note_failure({"unexpected status ", fmt_status(got)});
			end else begin
				want = status_q.pop_front();
				if (got.motor_id !== want.motor_id || got.phase !== want.phase ||
						got.drive !== want.drive || got.release_res !== want.release_res ||
						got.run_state !== want.run_state ||
						got.step_count !== want.step_count || got.last !== want.last)
					note_failure({"expected ", fmt_status(want), " actual ", fmt_status(got)});
			end
		end
	end

	task automatic test_quiet_tick();
		send_request(tick_req());
	endtask

	task automatic test_count_edges();
		send_request(count_req(2'd2, CNT_UP, 16'hFFFF));
		send_request(motion_req(2'd2, RUN_FWD, STOP_RUN, 4'd15));
		send_request(count_req(2'd3, CNT_DOWN, 16'd1));
		send_request(motion_req(2'd3, RUN_REV, STOP_RUN, 4'd0));
		repeat (2) send_request(tick_req());
	endtask

	task automatic test_slowest_stops();
		send_request(start_req(2'd0, RATE_SLOWEST));
		send_request(motion_req(2'd0, RUN_FWD, STOP_REVERSE, 4'd0));
		send_request(start_req(2'd1, RATE_SLOWEST));
		send_request(motion_req(2'd1, RUN_REV, STOP_RELEASE, 4'd15));
		repeat (16) send_request(tick_req());
	endtask

	task automatic test_odd_codes();
		send_request(motion_req(2'd2, RUN_ILLEGAL, STOP_HOLD, 4'd7));
		send_request(count_req(2'd1, CNT_ILLEGAL, 16'hA5A5));
		send_request(tick_req());
	endtask

	task automatic test_random_ramps(input int stop_at, input int idle);
		motor_req_t rq;
		int         p;
		int         q;
		logic [1:0] run;
		logic [1:0] stop;
		logic [3:0] target;
		logic [15:0] value;
		idle_pct = idle;
		while (sent_cnt < stop_at) begin
			repeat ($urandom_range(1, 4)) begin
				p = $urandom_range(99);
				if (p < 45) begin
					q = $urandom_range(9);
					run = (q < 4) ? RUN_FWD : (q < 8) ? RUN_REV : (q == 8) ? RUN_HOLD : RUN_ILLEGAL;
					q = $urandom_range(4);
					stop = (q < 2) ? STOP_RUN : (q == 2) ? STOP_HOLD :
						(q == 3) ? STOP_RELEASE : STOP_REVERSE;
					if ($urandom_range(2) == 0)
						target = ($urandom_range(1) != 0) ? RATE_SLOWEST : 4'd0;
					else
						target = 4'($urandom_range(15));
					rq = motion_req(2'($urandom_range(3)), run, stop, target);
				end else if (p < 70) begin
					q = $urandom_range(9);
					if (q < 5)
						value = 16'($urandom_range(8));
					else if (q < 7)
						value = 16'hFFFF - 16'($urandom_range(15));
					else
						value = 16'($urandom);
					rq = count_req(2'($urandom_range(3)), 2'($urandom_range(3)), value);
				end else begin
					if ($urandom_range(1) != 0)
						target = 4'($urandom_range(15, 12));
					else
						target = 4'($urandom_range(15));
					rq = start_req(2'($urandom_range(3)), target);
				end
				send_request(rq);
			end
			repeat ($urandom_range(1, 24)) send_request(tick_req());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = CMD_TICK;
		motor = '0;
		new_run_state = RUN_HOLD;
		new_stop_mode = STOP_RUN;
		target_rate = '0;
		start_rate = '0;
		new_count_mode = CNT_NONE;
		count_value = '0;
		for (int k = 0; k < MOTORS; k++)
			motor_model[k] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_pct = 30;
		test_quiet_tick();
		test_count_edges();
		test_slowest_stops();
		test_odd_codes();
		test_random_ramps(250, 30);
		test_random_ramps(320, 0);
		test_random_ramps(400, 35);
		test_random_ramps(480, 0);
		req_valid = 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (2 * MOTORS + 4) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
